// File: hdl/dgr_pkg.sv
package dgr_pkg;

  localparam int MaxNodes = 32;
  localparam int NodeW    = $clog2(MaxNodes);
  localparam int CountW   = 6;

  typedef enum logic [1:0] {
    ACT_CLEAR = 2'd0,
    ACT_ADD   = 2'd1,
    ACT_DEL   = 2'd2,
    ACT_QUERY = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EDGE,
    ST_SEARCH,
    ST_HOLD
  } state_e;

  typedef logic [MaxNodes-1:0] row_t;

  // Access request to the adjacency store
  typedef struct packed {
    logic             rd_en;
    logic [NodeW-1:0] rd_addr;
    logic             wr_en;
    logic [NodeW-1:0] wr_addr;
    row_t             wr_data;
    logic             clr;
  } adj_req_t;

endpackage

// File: hdl/dgr_adj_store.sv
module dgr_adj_store
  import dgr_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  adj_req_t req_i,
  output row_t     rd_row_o
);

  row_t                adj_mem_q [MaxNodes];
  logic [MaxNodes-1:0] row_vld_q;
  row_t                rd_data_q;
  logic                rd_vld_q;

  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      adj_mem_q[req_i.wr_addr] <= req_i.wr_data;
    end
    if (req_i.rd_en) begin
      rd_data_q <= adj_mem_q[req_i.rd_addr];
    end
  end

  // A row never written since reset or the last clear reads as empty
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_vld_q <= '0;
      rd_vld_q  <= 1'b0;
    end else begin
      if (req_i.clr) begin
        row_vld_q <= '0;
      end else if (req_i.wr_en) begin
        row_vld_q[req_i.wr_addr] <= 1'b1;
      end
      if (req_i.rd_en) begin
        rd_vld_q <= row_vld_q[req_i.rd_addr];
      end
    end
  end

  assign rd_row_o = rd_vld_q ? rd_data_q : '0;

endmodule

// File: hdl/directed_graph_reachability_top.sv
// Channel   Direction  Handshake                      Payload
// s_axis    in         s_axis_tvalid / s_axis_tready  tuser: action, tdata: src_node, dst_node
// m_axis    out        m_axis_tvalid / m_axis_tready  tuser: bad_node, tdata: path_exists
// cfg       in         cfg_valid_i / cfg_ready_o      cfg_data_i: node_count
//
// One item at a time. Clear, rejected items and queries whose source equals the
// destination go straight to the hold state, add/delete pass through the edge state
// (read-modify-write of one row), other queries read the rows of reached nodes (at most 32)
// while searching: the single read port of the adjacency memory gives one row per cycle.
// Reset empties the graph at once through per-row valid bits; node_count = 32.
// A result waits in the output register; the next item runs meanwhile and holds in the core.
module directed_graph_reachability_top
  import dgr_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [15:0]       s_axis_tdata,  // [4:0] src_node, [9:5] dst_node, rest zero
  input  logic [1:0]        s_axis_tuser,  // [1:0] action
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [7:0]        m_axis_tdata,  // [0] path_exists, rest zero
  output logic [0:0]        m_axis_tuser,  // [0] bad_node
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [CountW-1:0] cfg_data_i
);

  state_e state_q, state_d;

  logic [CountW-1:0] node_count_q;
  logic [CountW-1:0] cnt;
  row_t              active;

  action_e           in_act;
  logic [NodeW-1:0]  in_src, in_dst;
  logic              in_bad, in_fire;

  action_e           act_q, act_d;
  logic [NodeW-1:0]  src_q, src_d, dst_q, dst_d;
  row_t              reach_q, reach_d, proc_q, proc_d;
  logic              rd_pend_q, rd_pend_d;
  logic              res_path_q, res_path_d, res_bad_q, res_bad_d;
  logic              m_valid_q, m_path_q, m_bad_q;
  logic              out_load;

  adj_req_t          adj_req;
  row_t              rd_row;
  row_t              merged, cand, pick_oh;
  logic [NodeW-1:0]  pick_idx;
  logic              hit, exhausted;

  function automatic row_t node_bit(logic [NodeW-1:0] n);
    return row_t'(1) << n;
  endfunction

  dgr_adj_store u_store (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .req_i    (adj_req),
    .rd_row_o (rd_row)
  );

  // Configuration
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_count_q <= CountW'(MaxNodes);
    end else if (cfg_valid_i && cfg_ready_o) begin
      node_count_q <= cfg_data_i;
    end
  end

  assign cnt = (node_count_q > CountW'(MaxNodes)) ? CountW'(MaxNodes) : node_count_q;

  always_comb begin
    for (int i = 0; i < MaxNodes; i++) begin
      active[i] = (CountW'(i) < cnt);
    end
  end

  // Input decode
  assign in_act  = action_e'(s_axis_tuser);
  assign in_src  = s_axis_tdata[NodeW-1:0];
  assign in_dst  = s_axis_tdata[2*NodeW-1:NodeW];
  assign in_bad  = ({1'b0, in_src} >= cnt) || ({1'b0, in_dst} >= cnt);
  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_fire = s_axis_tvalid && s_axis_tready;

  // Search frontier: merge the row that just arrived, then pick the lowest
  // reached node whose row was not read yet
  assign merged    = reach_q | (rd_pend_q ? (rd_row & active) : '0);
  assign cand      = merged & ~proc_q;
  assign pick_oh   = cand & (~cand + row_t'(1));
  assign hit       = merged[dst_q];
  assign exhausted = (cand == '0);

  always_comb begin
    pick_idx = '0;
    for (int i = 0; i < MaxNodes; i++) begin
      if (pick_oh[i]) begin
        pick_idx = pick_idx | NodeW'(i);
      end
    end
  end

  assign out_load = (state_q == ST_HOLD) && (!m_valid_q || m_axis_tready);

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          unique case (in_act)
            ACT_CLEAR:        state_d = ST_HOLD;
            ACT_ADD, ACT_DEL: state_d = in_bad ? ST_HOLD : ST_EDGE;
            ACT_QUERY:        state_d = (in_bad || in_src == in_dst) ? ST_HOLD : ST_SEARCH;
            default:          state_d = ST_HOLD;
          endcase
        end
      end
      ST_EDGE:   state_d = ST_HOLD;
      ST_SEARCH: begin
        if (hit || exhausted) begin
          state_d = ST_HOLD;
        end
      end
      ST_HOLD: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default:   state_d = ST_IDLE;
    endcase
  end

  // Datapath and memory requests
  always_comb begin
    act_d      = act_q;
    src_d      = src_q;
    dst_d      = dst_q;
    reach_d    = reach_q;
    proc_d     = proc_q;
    rd_pend_d  = 1'b0;
    res_path_d = res_path_q;
    res_bad_d  = res_bad_q;
    adj_req    = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          act_d      = in_act;
          src_d      = in_src;
          dst_d      = in_dst;
          res_path_d = 1'b0;
          res_bad_d  = (in_act != ACT_CLEAR) && in_bad;
          unique case (in_act)
            ACT_CLEAR: adj_req.clr = 1'b1;
            ACT_ADD, ACT_DEL: begin
              adj_req.rd_en   = !in_bad;
              adj_req.rd_addr = in_src;
            end
            ACT_QUERY: begin
              if (!in_bad) begin
                reach_d    = node_bit(in_src);
                proc_d     = '0;
                res_path_d = (in_src == in_dst);
              end
            end
            default: ;
          endcase
        end
      end
      ST_EDGE: begin
        adj_req.wr_en   = 1'b1;
        adj_req.wr_addr = src_q;
        adj_req.wr_data = (act_q == ACT_ADD) ? (rd_row | node_bit(dst_q))
                                             : (rd_row & ~node_bit(dst_q));
      end
      ST_SEARCH: begin
        reach_d = merged;
        if (hit || exhausted) begin
          res_path_d = hit;
        end else begin
          adj_req.rd_en   = 1'b1;
          adj_req.rd_addr = pick_idx;
          proc_d          = proc_q | pick_oh;
          rd_pend_d       = 1'b1;
        end
      end
      ST_HOLD: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      rd_pend_q <= 1'b0;
      reach_q   <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      rd_pend_q <= rd_pend_d;
      reach_q   <= reach_d;
      if (out_load) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    act_q      <= act_d;
    src_q      <= src_d;
    dst_q      <= dst_d;
    proc_q     <= proc_d;
    res_path_q <= res_path_d;
    res_bad_q  <= res_bad_d;
    if (out_load) begin
      m_path_q <= res_path_q;
      m_bad_q  <= res_bad_q;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {7'b0, m_path_q};
  assign m_axis_tuser  = m_bad_q;

  // Assertions
  a_proc_in_reach: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SEARCH) |-> ((proc_q & ~reach_q) == '0))
    else $error("row read for a node outside the reached set");

  a_pend_has_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_pend_q |-> $past(adj_req.rd_en))
    else $error("merge of a row that was never read");

  a_accept_leaves_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> (state_q != ST_IDLE))
    else $error("accepted transaction left no work");

  a_hold_loads_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |=> (m_valid_q && state_q == ST_IDLE))
    else $error("result not moved to output register");

endmodule
